### design/hmmbc_pkg.sv
`default_nettype none

package hmmbc_pkg;

  // cartridge controller kinds, the unused code behaves as no controller
  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindMbc1 = 2'd1,
    KindMbc3 = 2'd2
  } kind_e;

  // address regions reported with each transaction
  typedef enum logic [3:0] {
    RegionBoot     = 4'd0,
    RegionRom0     = 4'd1,
    RegionRom1     = 4'd2,
    RegionVram     = 4'd3,
    RegionCartRam  = 4'd4,
    RegionWram     = 4'd5,
    RegionOam      = 4'd6,
    RegionUnusable = 4'd7,
    RegionIo       = 4'd8,
    RegionHighRam  = 4'd9,
    RegionSound    = 4'd10
  } region_e;

  localparam int unsigned KindWidth = 2;

  // reset values of the bank state
  localparam logic [6:0] RomBankReset = 7'd1;

  // fixed addresses and masks
  localparam logic [15:0] EchoMask      = 16'hDFFF;
  localparam logic [15:0] UnusableBase  = 16'hFEA0;
  localparam logic [15:0] SoundBase     = 16'hFF10;
  localparam logic [15:0] SoundLast     = 16'hFF3F;
  localparam logic [15:0] BootLatchAddr = 16'hFF50;
  localparam logic [15:0] LineCountAddr = 16'hFF44;
  localparam logic [4:0]  RamSelMax     = 5'h04;
  localparam logic [4:0]  ClockSelMin   = 5'h08;
  localparam logic [4:0]  ClockSelMax   = 5'h0C;

  // one bus access
  typedef struct packed {
    logic        req_type;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } req_t;

  // decode result and bank state after the access
  typedef struct packed {
    logic [3:0]  region;
    logic [15:0] mapped_addr;
    logic        access_ok;
    logic [6:0]  rom_bank_now;
    logic [2:0]  ram_bank_now;
    logic        clock_selected;
    logic [2:0]  clock_reg_now;
    logic        select_error;
  } rsp_t;

endpackage

`default_nettype wire

### design/handheld_memory_map_bank_controller.sv
// path from input transaction to the earliest result transaction:
// input register, then result register; decode and bank update are one shallow logic level
// throughput: one transaction per cycle unless the result register stalls
// while the result register stalls, an empty input register takes one more transaction
// reset: asynchronous active low, rom bank 1, ram bank 0, rom banking mode, clock select off,
// boot rom visible, controller kind none
`default_nettype none

module handheld_memory_map_bank_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [hmmbc_pkg::KindWidth-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  hmmbc_pkg::req_t                         in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output hmmbc_pkg::rsp_t                         out_data_o
);

  logic [hmmbc_pkg::KindWidth-1:0] kind_q;
  hmmbc_pkg::req_t  req_q;
  logic             req_valid_q;
  hmmbc_pkg::rsp_t  rsp_q, rsp_d;
  logic             rsp_valid_q;
  logic             advance;

  logic [6:0] rom_bank_q, rom_bank_d;
  logic [2:0] ram_bank_q, ram_bank_d;
  logic       mode_q, mode_d;
  logic       clk_acc_q, clk_acc_d;
  logic [2:0] clk_reg_q, clk_reg_d;
  logic [7:0] boot_q, boot_d;

  hmmbc_pkg::region_e region;
  logic [15:0] mapped;
  logic        ok;
  logic        err;
  logic [15:0] a;
  logic [7:0]  v;
  logic [4:0]  sel;

  // handshake, stage moves on when the result register is free or drained
  assign advance     = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

  assign a   = req_q.addr;
  assign v   = req_q.wdata;
  assign sel = v[4:0];

  // address decode
  always_comb begin
    mapped = a;
    ok     = 1'b1;
    priority if (a >= hmmbc_pkg::SoundBase && a <= hmmbc_pkg::SoundLast) begin
      region = hmmbc_pkg::RegionSound;
    end else if (a < 16'h0100 && boot_q == 8'd0) begin
      region = hmmbc_pkg::RegionBoot;
    end else if (a < 16'h4000) begin
      region = hmmbc_pkg::RegionRom0;
    end else if (a < 16'h8000) begin
      region = hmmbc_pkg::RegionRom1;
      mapped = a - 16'h4000;
    end else if (a < 16'hA000) begin
      region = hmmbc_pkg::RegionVram;
    end else if (a < 16'hC000) begin
      region = hmmbc_pkg::RegionCartRam;
      mapped = a - 16'hA000;
    end else if (a < 16'hE000) begin
      region = hmmbc_pkg::RegionWram;
    end else if (a < 16'hFE00) begin
      region = hmmbc_pkg::RegionWram;
      mapped = a & hmmbc_pkg::EchoMask;
    end else if (a < hmmbc_pkg::UnusableBase) begin
      region = hmmbc_pkg::RegionOam;
    end else if (a < 16'hFF00) begin
      region = hmmbc_pkg::RegionUnusable;
      ok     = 1'b0;
    end else if (a < 16'hFF80) begin
      region = hmmbc_pkg::RegionIo;
    end else begin
      region = hmmbc_pkg::RegionHighRam;
    end
  end

  // bank control and write effects
  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    mode_d     = mode_q;
    clk_acc_d  = clk_acc_q;
    clk_reg_d  = clk_reg_q;
    boot_d     = boot_q;
    err        = 1'b0;
    rsp_d      = '0;
    rsp_d.access_ok = ok;
    if (req_q.req_type && region != hmmbc_pkg::RegionSound) begin
      if (!a[15]) begin
        rsp_d.access_ok = 1'b0;
        unique case (hmmbc_pkg::kind_e'(kind_q))
          hmmbc_pkg::KindMbc1: begin
            unique case (a[14:13])
              2'b01: begin
                rom_bank_d = {rom_bank_q[6:5], (sel == 5'd0) ? 5'd1 : sel};
              end
              2'b10: begin
                if (mode_q) begin
                  ram_bank_d = {1'b0, v[1:0]};
                end else begin
                  rom_bank_d = {v[1:0], rom_bank_q[4:0]};
                end
              end
              2'b11: mode_d = v[0];
              default: ;
            endcase
          end
          hmmbc_pkg::KindMbc3: begin
            unique case (a[14:13])
              2'b01: rom_bank_d = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
              2'b10: begin
                priority if (sel <= hmmbc_pkg::RamSelMax) begin
                  ram_bank_d = sel[2:0];
                  clk_acc_d  = 1'b0;
                end else if (sel >= hmmbc_pkg::ClockSelMin &&
                             sel <= hmmbc_pkg::ClockSelMax) begin
                  clk_reg_d = sel[2:0];
                  clk_acc_d = 1'b1;
                end else begin
                  err = 1'b1;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end else if (a == hmmbc_pkg::LineCountAddr) begin
        rsp_d.access_ok = 1'b0;
      end else if (a == hmmbc_pkg::BootLatchAddr) begin
        if (boot_q != 8'd0) begin
          rsp_d.access_ok = 1'b0;
        end else begin
          boot_d = v;
        end
      end
    end
    rsp_d.region         = region;
    rsp_d.mapped_addr    = mapped;
    rsp_d.rom_bank_now   = rom_bank_d;
    rsp_d.ram_bank_now   = ram_bank_d;
    rsp_d.clock_selected = clk_acc_d;
    rsp_d.clock_reg_now  = clk_reg_d;
    rsp_d.select_error   = err;
  end

  // control and bank state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= hmmbc_pkg::KindNone;
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      rom_bank_q  <= hmmbc_pkg::RomBankReset;
      ram_bank_q  <= 3'd0;
      mode_q      <= 1'b0;
      clk_acc_q   <= 1'b0;
      clk_reg_q   <= 3'd0;
      boot_q      <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        kind_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
        rom_bank_q  <= rom_bank_d;
        ram_bank_q  <= ram_bank_d;
        mode_q      <= mode_d;
        clk_acc_q   <= clk_acc_d;
        clk_reg_q   <= clk_reg_d;
        boot_q      <= boot_d;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire
